FILE: design/tft_pkg.sv
// ---------------------------------------------------------------------------
// tft_pkg
// Types and constants shared by the triangle tessellator.
// ---------------------------------------------------------------------------
package tft_pkg;
    typedef logic signed [15:0] t_coord;
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vert;
    typedef struct packed {
        t_vert a;
        t_vert b;
        t_vert c;
    } t_face;
    typedef struct packed {
        t_vert p0;
        t_vert p1;
        t_vert p2;
        logic  last_of_face;
    } t_tri;
    localparam int VERT_W = $bits(t_vert);
    localparam logic [1:0] REG_DETAIL_LEVEL = 2'd0;
endpackage

FILE: design/tft_if.sv
// ---------------------------------------------------------------------------
// tft_face_if / tft_tri_if
// Valid/ready channels for input faces and output triangles.
// ---------------------------------------------------------------------------
interface tft_face_if;
    logic          valid;
    logic          ready;
    tft_pkg::t_face data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tft_tri_if;
    logic         valid;
    logic         ready;
    tft_pkg::t_tri data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/tft_ram.sv
// ---------------------------------------------------------------------------
// tft_ram
// Generic single-write, dual-read synchronous RAM with registered reads.
// ---------------------------------------------------------------------------
module tft_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule

FILE: design/tft_lerp.sv
// ---------------------------------------------------------------------------
// tft_lerp
// Multi-cycle lerp p + round((q-p)*num/den), den a positive value up to 8,
// with saturation. Division by a restoring divider, one bit per cycle.
// ---------------------------------------------------------------------------
module tft_lerp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tft_pkg::t_coord    i_p,
    input  tft_pkg::t_coord    i_q,
    input  logic [3:0]         i_num,
    input  logic [3:0]         i_den,
    output logic               o_done,
    output tft_pkg::t_coord    o_res
);
    import tft_pkg::*;

    localparam int QW = 22;

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [QW-1:0]     r_rem;
    logic [QW-1:0]     r_quo;
    logic [4:0]        r_dv;
    logic              r_neg;
    t_coord            r_p;

    logic signed [16:0] diff;
    logic signed [21:0] prod;
    logic [QW-1:0]      mag;
    logic [QW-1:0]      trial;
    logic signed [QW+1:0] sum;

    assign diff  = 17'(i_q) - 17'(i_p);
    assign prod  = 22'(diff) * $signed({18'd0, i_num});
    assign mag   = prod[21] ? QW'(-prod) : QW'(prod);
    assign trial = {r_rem[QW-2:0], r_quo[QW-1]};
    assign sum   = (QW+2)'(r_p) + (r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QW);
                // (2*mag + den) / (2*den)
                r_quo  <= QW'({mag, 1'b0} + QW'(i_den));
                r_rem  <= '0;
                r_dv   <= {i_den, 1'b0};
                r_neg  <= prod[21];
                r_p    <= i_p;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    if (sum > 24'sd32767) begin
                        o_res <= 16'sh7fff;
                    end else if (sum < -24'sd32768) begin
                        o_res <= 16'sh8000;
                    end else begin
                        o_res <= sum[15:0];
                    end
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                    if (trial >= QW'(r_dv)) begin
                        r_rem <= trial - QW'(r_dv);
                        r_quo <= {r_quo[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_quo <= {r_quo[QW-2:0], 1'b0};
                    end
                end
            end
        end
    end
endmodule

FILE: design/triangle_face_tessellator_top.sv
// Per row, the grid build runs a left and a right edge lerp for each of x, y and z,
// then per grid point a point lerp for each coordinate and a write; the apex row
// writes its single point from the left edge without point lerps. Emission then
// reads the grid and outputs the n*n sub-triangles of the face, with n = 2^d.
// Every lerp runs in one shared bit-serial divider. One face at a time. Reset
// clears control, the output valid flag and detail_level to 0.
// ---------------------------------------------------------------------------
// triangle_face_tessellator_top
// Builds a lerp grid in RAM and emits the sub-triangles row by row.
// ---------------------------------------------------------------------------
module triangle_face_tessellator_top #(
    parameter int MAX_DETAIL = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tft_face_if.sink    i_face,
    tft_tri_if.source   o_tri
);
    import tft_pkg::*;

    localparam int N    = 1 << MAX_DETAIL;
    localparam int DIM  = N + 1;
    localparam int DEP  = DIM * DIM;
    localparam int AW   = $clog2(DEP);
    localparam int IW   = $clog2(DIM+1);

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE_L, S_EDGE_R, S_PT, S_PT_WAIT, S_WR,
        S_EM_RD, S_EM_RD2, S_EM_OUT
    } t_state;

    t_state       r_state;
    logic [1:0]   r_detail;
    t_face        r_face;
    logic [IW-1:0] r_i, r_j, r_n;
    logic [1:0]   r_c;
    t_vert        r_left, r_right, r_pt;
    logic         r_odd;
    logic         r_start;
    t_coord       r_lp, r_lq;
    logic [3:0]   r_num, r_den;
    logic [6:0]   r_cnt, r_total;
    t_tri         r_out;
    logic         r_ovalid;
    t_vert        r_v0, r_v1;

    logic         lerp_done;
    t_coord       lerp_res;
    logic         we;
    logic [AW-1:0] waddr, ra0, ra1;
    logic [VERT_W-1:0] rd0, rd1;
    logic [1:0]   deff;
    logic [IW-1:0] span;

    assign pready = 1'b1;
    assign prdata = {30'd0, r_detail};
    assign deff   = (r_detail > 2'(MAX_DETAIL)) ? 2'(MAX_DETAIL) : r_detail;
    assign span   = r_n - r_i;

    function automatic logic [AW-1:0] addr(input logic [IW-1:0] i, input logic [IW-1:0] j);
        addr = AW'(i * DIM + j);
    endfunction

    function automatic t_coord pick(input t_vert v, input logic [1:0] c);
        unique case (c)
            2'd0:    pick = v.x;
            2'd1:    pick = v.y;
            default: pick = v.z;
        endcase
    endfunction

    function automatic t_vert put(input t_vert v, input logic [1:0] c, input t_coord x);
        t_vert r;
        r = v;
        unique case (c)
            2'd0:    r.x = x;
            2'd1:    r.y = x;
            default: r.z = x;
        endcase
        put = r;
    endfunction

    tft_lerp u_lerp (
        .i_clk, .i_rst_n, .i_start(r_start), .i_p(r_lp), .i_q(r_lq),
        .i_num(r_num), .i_den(r_den), .o_done(lerp_done), .o_res(lerp_res)
    );

    assign we    = (r_state == S_WR);
    assign waddr = addr(r_i, r_j);

    always_comb begin
        if (!r_odd) begin
            ra0 = addr(r_i, r_j + 1'b1);
            ra1 = addr(r_i + 1'b1, r_j);
        end else begin
            ra0 = addr(r_i, r_j + 1'b1);
            ra1 = addr(r_i + 1'b1, r_j + 1'b1);
        end
        // hold the third corner on port 0 while the triangle waits
        if (r_state == S_EM_RD2 || r_state == S_EM_OUT) begin
            ra0 = !r_odd ? addr(r_i, r_j) : addr(r_i + 1'b1, r_j);
        end
    end

    tft_ram #(.WIDTH(VERT_W), .DEPTH(DEP)) u_grid (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(r_pt),
        .i_raddr0(ra0), .i_raddr1(ra1), .o_rdata0(rd0), .o_rdata1(rd1)
    );

    assign i_face.ready = (r_state == S_IDLE);
    assign o_tri.valid  = r_ovalid;
    assign o_tri.data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_detail <= 2'd0;
            r_ovalid <= 1'b0;
            r_start  <= 1'b0;
            r_cnt    <= '0;
            r_total  <= '0;
        end else begin
            r_start <= 1'b0;
            if (psel && penable && pwrite && paddr[2] == REG_DETAIL_LEVEL[0]
                && paddr[1:0] == 2'b00) begin
                r_detail <= pwdata[1:0];
            end
            if (o_tri.valid && o_tri.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_face.valid) begin
                        r_face  <= i_face.data;
                        r_n     <= IW'(1) << deff;
                        r_total <= 7'(1) << {deff, 1'b0};
                        r_cnt   <= '0;
                        r_i     <= '0;
                        r_c     <= 2'd0;
                        r_lp    <= i_face.data.a.x;
                        r_lq    <= i_face.data.c.x;
                        r_num   <= 4'd0;
                        r_den   <= 4'(IW'(1) << deff);
                        r_start <= 1'b1;
                        r_state <= S_EDGE_L;
                    end
                end
                S_EDGE_L, S_EDGE_R: begin
                    if (lerp_done) begin
                        if (r_state == S_EDGE_L) begin
                            r_left  <= put(r_left, r_c, lerp_res);
                            r_lp    <= pick(r_face.b, r_c);
                            r_lq    <= pick(r_face.c, r_c);
                            r_start <= 1'b1;
                            r_state <= S_EDGE_R;
                        end else begin
                            r_right <= put(r_right, r_c, lerp_res);
                            if (r_c == 2'd2) begin
                                r_c <= 2'd0;
                                r_j <= '0;
                                r_state <= S_PT;
                            end else begin
                                r_c     <= r_c + 2'd1;
                                r_lp    <= pick(r_face.a, r_c + 2'd1);
                                r_lq    <= pick(r_face.c, r_c + 2'd1);
                                r_start <= 1'b1;
                                r_state <= S_EDGE_L;
                            end
                        end
                    end
                end
                S_PT: begin
                    if (span == '0) begin
                        r_pt    <= r_left;
                        r_state <= S_WR;
                    end else begin
                        r_lp    <= pick(r_left, r_c);
                        r_lq    <= pick(r_right, r_c);
                        r_num   <= 4'(r_j);
                        r_den   <= 4'(span);
                        r_start <= 1'b1;
                        r_state <= S_PT_WAIT;
                    end
                end
                S_PT_WAIT: begin
                    if (lerp_done) begin
                        r_pt <= put(r_pt, r_c, lerp_res);
                        if (r_c == 2'd2) begin
                            r_c <= 2'd0;
                            r_state <= S_WR;
                        end else begin
                            r_c <= r_c + 2'd1;
                            r_state <= S_PT;
                        end
                    end
                end
                S_WR: begin
                    if (r_j < span) begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_PT;
                    end else if (r_i < r_n) begin
                        r_i     <= r_i + 1'b1;
                        r_c     <= 2'd0;
                        r_lp    <= r_face.a.x;
                        r_lq    <= r_face.c.x;
                        r_num   <= 4'(r_i + 1'b1);
                        r_den   <= 4'(r_n);
                        r_start <= 1'b1;
                        r_state <= S_EDGE_L;
                    end else begin
                        r_i <= '0;
                        r_j <= '0;
                        r_odd <= 1'b0;
                        r_state <= S_EM_RD;
                    end
                end
                S_EM_RD: begin
                    r_state <= S_EM_RD2;
                end
                S_EM_RD2: begin
                    r_v0 <= rd0;
                    r_v1 <= rd1;
                    r_state <= S_EM_OUT;
                end
                S_EM_OUT: begin
                    if (!r_ovalid || o_tri.ready) begin
                        r_out.p0 <= r_v0;
                        r_out.p1 <= r_v1;
                        r_out.p2 <= rd0;
                        r_out.last_of_face <= (r_cnt + 7'd1 == r_total);
                        r_ovalid <= 1'b1;
                        r_cnt    <= r_cnt + 7'd1;
                        if (r_cnt + 7'd1 == r_total) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_EM_RD;
                            if (!r_odd) begin
                                if (r_j + 1'b1 == span) begin
                                    r_i <= r_i + 1'b1;
                                    r_j <= '0;
                                end else begin
                                    r_odd <= 1'b1;
                                end
                            end else begin
                                r_odd <= 1'b0;
                                r_j   <= r_j + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_face.valid && i_face.ready |=> r_state == S_EDGE_L)
        else $error("face accept did not start grid build");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_tri.ready |=> r_ovalid && $stable(r_out))
        else $error("stalled triangle changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_total)
        else $error("emitted more triangles than the face holds");
endmodule
